// ===== design/touch_contact_tracker_core_macros.svh =====
// Assertion macros used by the tracker RTL.
`ifndef TOUCH_CONTACT_TRACKER_CORE_MACROS_SVH
`define TOUCH_CONTACT_TRACKER_CORE_MACROS_SVH

// Checks cons in the same cycle whenever ante holds.
`define TCT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tracker assertion failed");

// Checks cons in the cycle after ante holds.
`define TCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tracker assertion failed");

`endif

// ===== design/tct_pkg.sv =====
package tct_pkg;

  typedef enum logic [1:0] {
    ACT_BEGAN,
    ACT_MOVED,
    ACT_ENDED,
    ACT_CANCELLED
  } action_t;

  typedef enum logic [2:0] {
    ST_REPORTED,
    ST_DUPLICATE,
    ST_NO_SLOT,
    ST_UNKNOWN,
    ST_UNCHANGED,
    ST_DISABLED
  } status_t;

  localparam logic [1:0] CFG_ENABLE       = 2'd0;
  localparam logic [1:0] CFG_TAP_INTERVAL = 2'd1;
  localparam logic [1:0] CFG_TAP_DEV      = 2'd2;

  localparam logic        ENABLE_RESET       = 1'b1;
  localparam logic [15:0] TAP_INTERVAL_RESET = 16'd300;
  localparam logic [15:0] TAP_DEV_RESET      = 16'd20;
  localparam logic [7:0]  TAP_MAX            = 8'd255;
  localparam logic [7:0]  TAP_FIRST          = 8'd1;

  typedef struct packed {
    action_t            action;
    logic [31:0]        touch_id;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic [31:0]        now_ms;
    logic               batch_end;
  } contact_in_t;

  typedef struct packed {
    status_t            status;
    action_t            event_kind;
    logic [3:0]         slot;
    logic [7:0]         tap_count;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic [31:0]        out_id;
    logic               group_end;
  } contact_out_t;

endpackage

// ===== design/touch_contact_tracker_core.sv =====
// Multitouch contact tracker. One contact transaction is taken in every cycle
// (busy stays low) and its single result appears on result, marked by
// result_valid for exactly one cycle; the receiver cannot hold it off. The
// contact passes through the input register and then the result register,
// between which the id compare and the lowest-free-slot pick run over all
// slots at once, so back-to-back transactions always see the state left by
// the one before.
`include "touch_contact_tracker_core_macros.svh"

module touch_contact_tracker_core
  import tct_pkg::*;
#(
  parameter int SLOT_COUNT = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  contact_in_t  item,
  output logic         result_valid,
  output contact_out_t result,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic        touch_enable;
  logic [15:0] tap_interval_ms;
  logic [15:0] tap_radius;

  logic        in_valid;
  contact_in_t in_item;

  logic [SLOT_COUNT-1:0] slot_busy;
  logic [SLOT_COUNT-1:0] slot_busy_next;
  logic [31:0]           slot_contact [SLOT_COUNT];
  logic signed [15:0]    slot_px      [SLOT_COUNT];
  logic signed [15:0]    slot_py      [SLOT_COUNT];
  logic [7:0]            slot_taps    [SLOT_COUNT];
  logic [31:0]           prev_tap_time;
  logic signed [15:0]    prev_tap_x;
  logic signed [15:0]    prev_tap_y;

  logic [SLOT_COUNT-1:0] hit_vec;
  logic [SLOT_COUNT-1:0] same_vec;
  logic                  id_found;
  logic                  free_found;
  logic [SW-1:0]         hit_idx;
  logic [SW-1:0]         free_idx;
  logic [SW-1:0]         sel_idx;
  logic [SW+3:0]         sel_idx_ext;
  logic [31:0]           gap;
  logic signed [16:0]    dx;
  logic signed [16:0]    dy;
  logic [16:0]           adx;
  logic [16:0]           ady;
  logic                  tap_repeat;
  logic [7:0]            taps_new;
  logic                  do_begin;
  logic                  do_update;
  contact_out_t          result_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      touch_enable    <= ENABLE_RESET;
      tap_interval_ms <= TAP_INTERVAL_RESET;
      tap_radius      <= TAP_DEV_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE:       touch_enable    <= cfg_data[0];
        CFG_TAP_INTERVAL: tap_interval_ms <= cfg_data;
        CFG_TAP_DEV:      tap_radius      <= cfg_data;
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    if (start && !busy) begin
      in_item <= item;
    end
  end

  always_comb begin
    hit_idx    = '0;
    free_idx   = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      hit_vec[i]  = slot_busy[i] && (slot_contact[i] == in_item.touch_id);
      same_vec[i] = (slot_px[i] == in_item.x_pos) && (slot_py[i] == in_item.y_pos);
    end
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = SW'(i);
      end
      if (!slot_busy[i]) begin
        free_idx = SW'(i);
      end
    end
    id_found   = |hit_vec;
    free_found = !(&slot_busy);
  end

  always_comb begin
    gap = in_item.now_ms - prev_tap_time;
    dx  = {in_item.x_pos[15], in_item.x_pos} - {prev_tap_x[15], prev_tap_x};
    dy  = {in_item.y_pos[15], in_item.y_pos} - {prev_tap_y[15], prev_tap_y};
    adx = dx[16] ? 17'(-dx) : 17'(dx);
    ady = dy[16] ? 17'(-dy) : 17'(dy);
    tap_repeat = (gap <= {16'd0, tap_interval_ms}) &&
                 (adx <= {1'b0, tap_radius}) && (ady <= {1'b0, tap_radius});
    if (!tap_repeat) begin
      taps_new = TAP_FIRST;
    end else if (slot_taps[free_idx] == TAP_MAX) begin
      taps_new = TAP_MAX;
    end else begin
      taps_new = slot_taps[free_idx] + 8'd1;
    end
  end

  always_comb begin
    do_begin       = 1'b0;
    do_update      = 1'b0;
    sel_idx        = hit_idx;
    slot_busy_next = slot_busy;
    result_next    = '0;
    result_next.event_kind = in_item.action;
    result_next.group_end  = in_item.batch_end;
    result_next.status     = ST_REPORTED;
    if (!touch_enable) begin
      result_next.status = ST_DISABLED;
      if (in_item.action == ACT_ENDED || in_item.action == ACT_CANCELLED) begin
        slot_busy_next = '0;
      end
    end else if (in_item.action == ACT_BEGAN) begin
      sel_idx = free_idx;
      if (id_found) begin
        result_next.status = ST_DUPLICATE;
      end else if (!free_found) begin
        result_next.status = ST_NO_SLOT;
      end else begin
        do_begin                 = 1'b1;
        slot_busy_next[free_idx] = 1'b1;
      end
    end else if (!id_found) begin
      result_next.status = ST_UNKNOWN;
    end else if (in_item.action == ACT_MOVED && |(hit_vec & same_vec)) begin
      result_next.status = ST_UNCHANGED;
    end else begin
      do_update = 1'b1;
      if (in_item.action != ACT_MOVED) begin
        slot_busy_next[hit_idx] = 1'b0;
      end
    end
    sel_idx_ext = {4'd0, sel_idx};
    if (result_next.status == ST_REPORTED) begin
      result_next.slot      = sel_idx_ext[3:0];
      result_next.tap_count = do_begin ? taps_new : slot_taps[hit_idx];
      result_next.out_x     = in_item.x_pos;
      result_next.out_y     = in_item.y_pos;
      result_next.out_id    = in_item.touch_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_busy     <= '0;
      prev_tap_time <= '0;
      prev_tap_x    <= '0;
      prev_tap_y    <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_taps[i] <= '0;
      end
    end else if (in_valid) begin
      slot_busy <= slot_busy_next;
      if (do_begin) begin
        slot_taps[free_idx] <= taps_new;
        prev_tap_time       <= in_item.now_ms;
        prev_tap_x          <= in_item.x_pos;
        prev_tap_y          <= in_item.y_pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && (do_begin || do_update)) begin
      slot_px[sel_idx] <= in_item.x_pos;
      slot_py[sel_idx] <= in_item.y_pos;
      if (do_begin) begin
        slot_contact[sel_idx] <= in_item.touch_id;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= in_valid;
    end
    if (in_valid) begin
      result <= result_next;
    end
  end

  `TCT_ASSERT_NOW(a_result_follows_input, !$past(rst), result_valid == $past(in_valid))
  `TCT_ASSERT_NOW(a_rejected_is_blank, result_valid && result.status != ST_REPORTED, result.tap_count == 8'd0 && result.out_id == 32'd0 && result.slot == 4'd0)
  `TCT_ASSERT_NOW(a_began_has_taps, result_valid && result.status == ST_REPORTED && result.event_kind == ACT_BEGAN, result.tap_count != 8'd0)
  `TCT_ASSERT_NEXT(a_began_fills_slot, in_valid && do_begin, slot_busy != '0)

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tct_pkg::*;

  localparam int SLOT_TOTAL = 16;
  localparam int ITEM_TARGET = 1450;
  localparam int STALL_LIMIT = 2000;
  localparam int REPORT_LIMIT = 10;

  logic         clk;
  logic         rst;
  logic         start;
  logic         busy;
  contact_in_t  item;
  logic         result_valid;
  contact_out_t result;
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [15:0]  cfg_data;

  touch_contact_tracker_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Shadow copy of the tracker state and its registers.
  logic               held [SLOT_TOTAL];
  logic [31:0]        held_id [SLOT_TOTAL];
  logic signed [15:0] held_x [SLOT_TOTAL];
  logic signed [15:0] held_y [SLOT_TOTAL];
  logic [7:0]         taps [SLOT_TOTAL];
  logic [31:0]        last_tap_ms;
  logic signed [15:0] last_tap_x;
  logic signed [15:0] last_tap_y;
  logic               track_on;
  logic [15:0]        repeat_window_ms;
  logic [15:0]        repeat_radius;

  contact_out_t contact_reports_due[$];
  contact_out_t want;
  logic [31:0]  clock_ms;
  bit           idle_on;
  int           sent_count;
  int           checked_count;
  int           reg_writes;
  int           mismatch_count;
  int           failures;
  int           stall_cycles;
  int           status_tally [6];
  int           top_tap_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int slot_of_id(logic [31:0] id);
    for (int i = 0; i < SLOT_TOTAL; i++) begin
      if (held[i] && held_id[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic contact_out_t track_contact(contact_in_t ev);
    contact_out_t r;
    int           s;
    int           dx;
    int           dy;
    logic [31:0]  gap;
    r = '0;
    r.status = ST_REPORTED;
    r.event_kind = ev.action;
    r.group_end = ev.batch_end;
    s = -1;
    if (!track_on) begin
      r.status = ST_DISABLED;
      if (ev.action == ACT_ENDED || ev.action == ACT_CANCELLED) begin
        for (int i = 0; i < SLOT_TOTAL; i++) held[i] = 1'b0;
      end
    end else if (ev.action == ACT_BEGAN) begin
      if (slot_of_id(ev.touch_id) >= 0) begin
        r.status = ST_DUPLICATE;
      end else begin
        for (int i = SLOT_TOTAL - 1; i >= 0; i--) begin
          if (!held[i]) s = i;
        end
        if (s < 0) begin
          r.status = ST_NO_SLOT;
        end else begin
          gap = ev.now_ms - last_tap_ms;
          dx = $signed(ev.x_pos) - $signed(last_tap_x);
          dy = $signed(ev.y_pos) - $signed(last_tap_y);
          if (dx < 0) dx = -dx;
          if (dy < 0) dy = -dy;
          if (gap <= {16'd0, repeat_window_ms} && dx <= int'(repeat_radius) &&
              dy <= int'(repeat_radius)) begin
            if (taps[s] != TAP_MAX) taps[s] = taps[s] + 8'd1;
          end else begin
            taps[s] = TAP_FIRST;
          end
          last_tap_ms = ev.now_ms;
          last_tap_x = ev.x_pos;
          last_tap_y = ev.y_pos;
          held[s] = 1'b1;
          held_id[s] = ev.touch_id;
          held_x[s] = ev.x_pos;
          held_y[s] = ev.y_pos;
        end
      end
    end else begin
      s = slot_of_id(ev.touch_id);
      if (s < 0) begin
        r.status = ST_UNKNOWN;
      end else if (ev.action == ACT_MOVED && held_x[s] == ev.x_pos &&
                   held_y[s] == ev.y_pos) begin
        r.status = ST_UNCHANGED;
      end else begin
        held_x[s] = ev.x_pos;
        held_y[s] = ev.y_pos;
        if (ev.action != ACT_MOVED) held[s] = 1'b0;
      end
    end
    if (r.status == ST_REPORTED && s >= 0) begin
      r.slot = 4'(s);
      r.tap_count = taps[s];
      r.out_x = held_x[s];
      r.out_y = held_y[s];
      r.out_id = held_id[s];
      if (int'(taps[s]) > top_tap_count) top_tap_count = int'(taps[s]);
    end
    status_tally[int'(r.status)]++;
    return r;
  endfunction

  function automatic contact_in_t make_contact(action_t act, logic [31:0] id,
                                               logic [15:0] x, logic [15:0] y,
                                               logic [31:0] ms, logic bend);
    contact_in_t ev;
    ev.action = act;
    ev.touch_id = id;
    ev.x_pos = x;
    ev.y_pos = y;
    ev.now_ms = ms;
    ev.batch_end = bend;
    return ev;
  endfunction

  // Mostly well-formed contact traffic: begins near the last tap, moves and
  // ends of contacts that are held, plus a share of unknown ids and noise.
  function automatic contact_in_t pick_contact();
    contact_in_t ev;
    int          live[$];
    int          s;
    int          off_x;
    int          off_y;
    int          begin_pct;
    int          roll;
    for (int i = 0; i < SLOT_TOTAL; i++) begin
      if (held[i]) live.push_back(i);
    end
    roll = $urandom_range(99);
    if (roll < 3) clock_ms = $urandom();
    else if (roll < 13) clock_ms = clock_ms;
    else clock_ms = clock_ms + $urandom_range(0, 400);
    ev.now_ms = clock_ms;
    ev.batch_end = 1'($urandom_range(1));
    ev.touch_id = $urandom();
    ev.x_pos = 16'($urandom());
    ev.y_pos = 16'($urandom());
    off_x = ($urandom_range(99) < 20) ? 0 : int'($urandom_range(0, 40)) - 20;
    off_y = ($urandom_range(99) < 20) ? 0 : int'($urandom_range(0, 40)) - 20;
    begin_pct = (live.size() >= SLOT_TOTAL) ? 10 : 55 - 3 * live.size();
    s = (live.size() > 0) ? live[$urandom_range(live.size() - 1)] : -1;
    roll = $urandom_range(99);
    if (!track_on) begin
      ev.action = action_t'($urandom_range(3));
    end else if (roll < begin_pct) begin
      ev.action = ACT_BEGAN;
      if (s >= 0 && $urandom_range(99) < 8) ev.touch_id = held_id[s];
      if ($urandom_range(99) < 70) begin
        ev.x_pos = last_tap_x + 16'(off_x);
        ev.y_pos = last_tap_y + 16'(off_y);
      end
    end else if (s < 0 || $urandom_range(99) < 10) begin
      ev.action = action_t'($urandom_range(3));
    end else begin
      ev.touch_id = held_id[s];
      roll = $urandom_range(99);
      if (roll < 50) ev.action = ACT_MOVED;
      else if (roll < 75) ev.action = ACT_ENDED;
      else ev.action = ACT_CANCELLED;
      if ($urandom_range(99) < 20) begin
        ev.x_pos = held_x[s];
        ev.y_pos = held_y[s];
      end else if ($urandom_range(99) < 85) begin
        ev.x_pos = held_x[s] + 16'(off_x);
        ev.y_pos = held_y[s] + 16'(off_y);
      end
    end
    return ev;
  endfunction

  task automatic send_contact(input contact_in_t ev);
    while (idle_on && $urandom_range(99) < 9) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item <= ev;
    do @(posedge clk); while (busy);
    contact_reports_due.push_back(track_contact(ev));
    sent_count++;
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    while (contact_reports_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_tracker_reg(input logic [1:0] idx, input logic [15:0] value);
    wait_all_results();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      CFG_ENABLE:       track_on = value[0];
      CFG_TAP_INTERVAL: repeat_window_ms = value;
      CFG_TAP_DEV:      repeat_radius = value;
      default: ;
    endcase
    reg_writes++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic en, input logic [15:0] window_ms,
                                input logic [15:0] radius);
    write_tracker_reg(CFG_ENABLE, {15'd0, en});
    write_tracker_reg(CFG_TAP_INTERVAL, window_ms);
    write_tracker_reg(CFG_TAP_DEV, radius);
  endtask

  task automatic release_all_contacts();
    for (int i = 0; i < SLOT_TOTAL; i++) begin
      if (held[i] && track_on) begin
        send_contact(make_contact(ACT_ENDED, held_id[i], held_x[i], held_y[i],
                                  clock_ms, 1'b0));
      end
    end
  endtask

  task automatic test_basic_actions();
    send_contact(make_contact(ACT_BEGAN, 32'hFFFF_FFFF, 16'h0000, 16'h0000,
                              32'hFFFF_FFFF, 1'b1));
    send_contact(make_contact(ACT_BEGAN, 32'hFFFF_FFFF, 16'h0001, 16'h0001,
                              32'h0000_0000, 1'b0));
    send_contact(make_contact(ACT_MOVED, 32'hFFFF_FFFF, 16'h0000, 16'h0000,
                              32'h0000_0001, 1'b1));
    send_contact(make_contact(ACT_MOVED, 32'hFFFF_FFFF, 16'h7FFF, 16'h8000,
                              32'h0000_0002, 1'b0));
    send_contact(make_contact(ACT_MOVED, 32'h8000_0000, 16'h1234, 16'h4321,
                              32'h0000_0003, 1'b1));
    send_contact(make_contact(ACT_ENDED, 32'h8000_0000, 16'hFFFF, 16'h0000,
                              32'h0000_0004, 1'b0));
    send_contact(make_contact(ACT_CANCELLED, 32'h1234_5678, 16'h8000, 16'h7FFF,
                              32'h0000_0005, 1'b1));
  endtask

  task automatic test_slot_exhaustion();
    for (int i = 0; i < SLOT_TOTAL - 1; i++) begin
      send_contact(make_contact(ACT_BEGAN, 32'(i), 16'(3 * i), 16'(-3 * i),
                                32'(10 + 20 * i), 1'(i)));
    end
    send_contact(make_contact(ACT_BEGAN, 32'h0BAD_F00D, 16'h0000, 16'h0000,
                              32'h0000_0200, 1'b1));
    send_contact(make_contact(ACT_CANCELLED, 32'hFFFF_FFFF, 16'h8000, 16'h7FFF,
                              32'h0000_0210, 1'b0));
  endtask

  task automatic test_time_wrap();
    send_contact(make_contact(ACT_BEGAN, 32'hA5A5_5A5A, 16'h0005, 16'h0005,
                              32'hFFFF_FF80, 1'b0));
    send_contact(make_contact(ACT_ENDED, 32'hA5A5_5A5A, 16'h0005, 16'h0005,
                              32'hFFFF_FFA0, 1'b1));
    send_contact(make_contact(ACT_BEGAN, 32'h5A5A_A5A5, 16'h0019, 16'hFFF1,
                              32'h0000_00AC, 1'b0));
    send_contact(make_contact(ACT_ENDED, 32'h5A5A_A5A5, 16'h0019, 16'hFFF1,
                              32'h0000_00B0, 1'b1));
    clock_ms = 32'h0000_0100;
  endtask

  task automatic test_tap_saturation();
    logic [31:0] id;
    release_all_contacts();
    apply_settings(1'b1, 16'hFFFF, 16'hFFFF);
    for (int n = 0; n < 260; n++) begin
      id = $urandom();
      clock_ms = clock_ms + $urandom_range(0, 2000);
      send_contact(make_contact(ACT_BEGAN, id, 16'($urandom()), 16'($urandom()),
                                clock_ms, 1'($urandom_range(1))));
      send_contact(make_contact($urandom_range(1) ? ACT_ENDED : ACT_CANCELLED, id,
                                16'($urandom()), 16'($urandom()), clock_ms,
                                1'($urandom_range(1))));
    end
  endtask

  task automatic test_random_traffic();
    int phase;
    int count;
    phase = 0;
    while (sent_count < ITEM_TARGET) begin
      count = 150;
      idle_on = 1'b1;
      case (phase)
        0: apply_settings(1'b1, TAP_INTERVAL_RESET, TAP_DEV_RESET);
        1: apply_settings(1'b1, 16'd0, 16'd0);
        2: apply_settings(1'b1, 16'hFFFF, 16'hFFFF);
        3: apply_settings(1'b1, 16'($urandom()), 16'($urandom_range(0, 64)));
        4: begin
          apply_settings(1'b1, 16'd1000, 16'd5);
          idle_on = 1'b0;
        end
        5: begin
          apply_settings(1'b0, TAP_INTERVAL_RESET, TAP_DEV_RESET);
          count = 40;
        end
        default: apply_settings(1'b1, 16'($urandom_range(0, 2000)),
                                16'($urandom_range(0, 100)));
      endcase
      for (int n = 0; n < count && sent_count < ITEM_TARGET; n++) begin
        if (phase == 2 && n == count / 2) wait_all_results();
        send_contact(pick_contact());
      end
      phase++;
    end
    idle_on = 1'b1;
  endtask

  always @(negedge clk) begin
    if (!rst && result_valid === 1'b1) begin
      if (contact_reports_due.size() == 0) begin
        failures++;
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("unexpected result: status=%0d kind=%0d slot=%0d taps=%0d id=%h",
                   result.status, result.event_kind, result.slot, result.tap_count,
                   result.out_id);
        end
      end else begin
        want = contact_reports_due.pop_front();
        checked_count++;
        if (result.status !== want.status || result.event_kind !== want.event_kind ||
            result.slot !== want.slot || result.tap_count !== want.tap_count ||
            result.out_x !== want.out_x || result.out_y !== want.out_y ||
            result.out_id !== want.out_id || result.group_end !== want.group_end) begin
          failures++;
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("mismatch on result %0d:", checked_count);
            $display("  expected status=%0d kind=%0d slot=%0d taps=%0d x=%0d y=%0d id=%h end=%0d",
                     want.status, want.event_kind, want.slot, want.tap_count,
                     want.out_x, want.out_y, want.out_id, want.group_end);
            $display("  actual   status=%0d kind=%0d slot=%0d taps=%0d x=%0d y=%0d id=%h end=%0d",
                     result.status, result.event_kind, result.slot, result.tap_count,
                     result.out_x, result.out_y, result.out_id, result.group_end);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || cfg_we) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Watchdog expired with %0d results outstanding.",
                 contact_reports_due.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    item <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_ENABLE;
    cfg_data <= '0;
    for (int i = 0; i < SLOT_TOTAL; i++) begin
      held[i] = 1'b0;
      held_id[i] = '0;
      held_x[i] = '0;
      held_y[i] = '0;
      taps[i] = '0;
    end
    for (int i = 0; i < 6; i++) status_tally[i] = 0;
    last_tap_ms = '0;
    last_tap_x = '0;
    last_tap_y = '0;
    track_on = ENABLE_RESET;
    repeat_window_ms = TAP_INTERVAL_RESET;
    repeat_radius = TAP_DEV_RESET;
    clock_ms = '0;
    idle_on = 1'b1;
    sent_count = 0;
    checked_count = 0;
    reg_writes = 0;
    mismatch_count = 0;
    failures = 0;
    stall_cycles = 0;
    top_tap_count = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_basic_actions();
    test_slot_exhaustion();
    test_time_wrap();
    test_tap_saturation();
    test_random_traffic();

    wait_all_results();
    if (contact_reports_due.size() != 0) failures++;
    $display("Ran %0d contact transactions, checked %0d results, %0d register writes.",
             sent_count, checked_count, reg_writes);
    $display("Reported %0d, duplicate %0d, no slot %0d, unknown %0d, unchanged %0d, disabled %0d; peak tap count %0d; %0d mismatches.",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3],
             status_tally[4], status_tally[5], top_tap_count, mismatch_count);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
